FILE: rtl/crb_pkg.sv
// Shared types and constants for the CAN id range to filter bank packer.
`default_nettype none
package crb_pkg;

	// command codes
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_ADD_STD = 2'd1;
	localparam logic [1:0] CMD_ADD_EXT = 2'd2;
	localparam logic [1:0] CMD_FLUSH   = 2'd3;

	// completion status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int unsigned BANK_CAP_DEF = 28;
	localparam logic [4:0] BANK_LIMIT_RST = 5'd14;
	localparam logic [28:0] STD_ID_MAX = 29'h0000_07FF;
	localparam logic [28:0] EXT_ID_MAX = 29'h1FFF_FFFF;

	// commands from controller to datapath
	typedef struct packed {
		logic       load;
		logic       step;
		logic       flush_sl;
		logic       flush_sm;
		logic       flush_el;
		logic       put_status;
		logic [1:0] status;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic bad;
		logic emit;
		logic full;
		logic done;
		logic at_limit;
		logic out_free;
		logic sl_nz;
		logic sm_nz;
		logic el_nz;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/can_id_range_to_filter_banks.sv
// Top level of the CAN id range to filter bank packer.
// Each command word is accepted while the sequencer is idle. An add command then steps
// through the aligned blocks of the range, one block per cycle while the output register
// is free (a range splits into at most about 56 blocks), and a flush steps through the
// three kinds of partial bank in turn; the final status word comes last. Every step that
// writes a word waits while the output register is still held by the consumer. A clear
// or a rejected range goes straight to the status word. bank_limit is written through
// the cfg channel, which is always ready; values above BANK_CAP act as BANK_CAP. No clearing pass follows reset.
`default_nettype none
module can_id_range_to_filter_banks #(
	parameter int unsigned BANK_CAP = crb_pkg::BANK_CAP_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [28:0] range_begin,
	input  wire logic [28:0] range_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             is_status,
	output logic [4:0]       bank_index,
	output logic [31:0]      reg_first,
	output logic [31:0]      reg_second,
	output logic             wide_mode,
	output logic             list_mode,
	output logic [1:0]       status,
	output logic             last
);

	crb_pkg::ctrl_cmd_t ctl;
	crb_pkg::dp_stat_t  stat;

	// sequence commands
	crb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.stat     (stat),
		.ctl      (ctl)
	);

	// split ranges and pack banks
	crb_dp #(
		.BANK_CAP (BANK_CAP)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.range_begin (range_begin),
		.range_end   (range_end),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.ctl         (ctl),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_status   (is_status),
		.bank_index  (bank_index),
		.reg_first   (reg_first),
		.reg_second  (reg_second),
		.wide_mode   (wide_mode),
		.list_mode   (list_mode),
		.status      (status),
		.last        (last)
	);

endmodule
`default_nettype wire

FILE: rtl/crb_ctrl.sv
// Command sequencer of the CAN id range to filter bank packer.
`default_nettype none
module crb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        cmd,
	input  crb_pkg::dp_stat_t      stat,
	output crb_pkg::ctrl_cmd_t     ctl
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_RANGE  = 6'b000010,
		S_FL_SL  = 6'b000100,
		S_FL_SM  = 6'b001000,
		S_FL_EL  = 6'b010000,
		S_STATUS = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] st_q, st_d;

	assign in_ready = (state_q == S_IDLE);

	// sequence the steps of one command
	always_comb begin
		state_d = state_q;
		st_d = st_q;
		ctl = '0;
		ctl.status = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					st_d = crb_pkg::ST_OK;
					case (cmd)
						crb_pkg::CMD_CLEAR: state_d = S_STATUS;
						crb_pkg::CMD_ADD_STD, crb_pkg::CMD_ADD_EXT: begin
							if (stat.bad) begin
								st_d = crb_pkg::ST_RANGE;
								state_d = S_STATUS;
							end else begin
								state_d = S_RANGE;
							end
						end
						default: state_d = S_FL_SL;
					endcase
				end
			end
			S_RANGE: begin
				if (stat.out_free) begin
					ctl.step = 1'b1;
					if (stat.emit && stat.full) begin
						st_d = crb_pkg::ST_FULL;
						state_d = S_STATUS;
					end else if (stat.done) begin
						state_d = S_STATUS;
					end
				end
			end
			S_FL_SL: begin
				if (stat.out_free) begin
					ctl.flush_sl = 1'b1;
					if (stat.sl_nz && stat.at_limit) begin
						st_d = crb_pkg::ST_FULL;
						state_d = S_STATUS;
					end else begin
						state_d = S_FL_SM;
					end
				end
			end
			S_FL_SM: begin
				if (stat.out_free) begin
					ctl.flush_sm = 1'b1;
					if (stat.sm_nz && stat.at_limit) begin
						st_d = crb_pkg::ST_FULL;
						state_d = S_STATUS;
					end else begin
						state_d = S_FL_EL;
					end
				end
			end
			S_FL_EL: begin
				if (stat.out_free) begin
					ctl.flush_el = 1'b1;
					if (stat.el_nz && stat.at_limit) begin
						st_d = crb_pkg::ST_FULL;
					end
					state_d = S_STATUS;
				end
			end
			S_STATUS: begin
				if (stat.out_free) begin
					ctl.put_status = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// hold state and status code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= crb_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/crb_dp.sv
// Datapath: block splitter, pending entries, bank counter and output word register.
`default_nettype none
module crb_dp #(
	parameter int unsigned BANK_CAP = crb_pkg::BANK_CAP_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [1:0]        cmd,
	input  wire logic [28:0]       range_begin,
	input  wire logic [28:0]       range_end,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [4:0]        cfg_data,
	input  crb_pkg::ctrl_cmd_t     ctl,
	output crb_pkg::dp_stat_t      stat,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   is_status,
	output logic [4:0]             bank_index,
	output logic [31:0]            reg_first,
	output logic [31:0]            reg_second,
	output logic                   wide_mode,
	output logic                   list_mode,
	output logic [1:0]             status,
	output logic                   last
);

	localparam logic [4:0] MaxB = 5'(BANK_CAP);

	logic [4:0]  limit_q, bank_count_q, lim;
	logic [28:0] cur_q, hi_q;
	logic        ext_q;
	logic [10:0] sl_q [4];
	logic [1:0]  sl_fill_q;
	logic [21:0] sm_q [2];
	logic        sm_fill_q;
	logic [28:0] el_q [2];
	logic        el_fill_q;
	logic        out_valid_q;

	logic [28:0] top, lowbit29, mask, lo_in, hi_in;
	logic [29:0] rem, sm1, sm2, sm3, sm4, sm5, msb, lowbit, size, last_id;
	logic        is_list, emit, full, load_bank, at_limit, out_free;
	logic [31:0] r1, r2;
	logic        wide, listm;
	logic [21:0] sm_new;

	assign cfg_ready = 1'b1;
	assign lim = (limit_q > MaxB) ? MaxB : limit_q;
	assign at_limit = (bank_count_q >= lim);
	assign out_free = !out_valid_q || out_ready;

	// order the bounds of an incoming range
	assign lo_in = (range_begin > range_end) ? range_end : range_begin;
	assign hi_in = (range_begin > range_end) ? range_begin : range_end;

	// size the largest aligned block at the cursor that stays within the range
	assign top = ext_q ? crb_pkg::EXT_ID_MAX : crb_pkg::STD_ID_MAX;
	assign rem = {1'b0, hi_q} - {1'b0, cur_q} + 30'd1;
	assign sm1 = rem | (rem >> 1);
	assign sm2 = sm1 | (sm1 >> 2);
	assign sm3 = sm2 | (sm2 >> 4);
	assign sm4 = sm3 | (sm3 >> 8);
	assign sm5 = sm4 | (sm4 >> 16);
	assign msb = sm5 ^ (sm5 >> 1);
	assign lowbit29 = cur_q & (~cur_q + 29'd1);
	assign lowbit = (cur_q == '0) ? (ext_q ? 30'h2000_0000 : 30'h0000_0800)
		: {1'b0, lowbit29};
	assign size = (lowbit < msb) ? lowbit : msb;
	assign mask = ~(size[28:0] - 29'd1) & top;
	assign is_list = (size == 30'd1);
	assign last_id = {1'b0, cur_q} + size - 30'd1;
	assign sm_new = {mask[10:0], cur_q[10:0]};

	// pick the bank a step completes
	always_comb begin
		emit = 1'b0;
		r1 = '0;
		r2 = '0;
		wide = ext_q;
		listm = is_list;
		if (!ext_q && is_list) begin
			emit = (sl_fill_q == 2'd3);
			r1 = {sl_q[1], 5'd0, sl_q[0], 5'd0};
			r2 = {cur_q[10:0], 5'd0, sl_q[2], 5'd0};
		end else if (!ext_q) begin
			emit = sm_fill_q;
			r1 = {sm_q[0][21:11], 5'd0, sm_q[0][10:0], 5'd0};
			r2 = {sm_new[21:11], 5'd0, sm_new[10:0], 5'd0};
		end else if (is_list) begin
			emit = el_fill_q;
			r1 = {el_q[0], 3'b100};
			r2 = {cur_q, 3'b100};
		end else begin
			emit = 1'b1;
			r1 = {cur_q, 3'b100};
			r2 = {mask, 3'b000};
		end
	end

	assign full = emit && at_limit;
	assign load_bank = (ctl.step && emit && !full)
		|| (ctl.flush_sl && sl_fill_q != 2'd0 && !at_limit)
		|| (ctl.flush_sm && sm_fill_q && !at_limit)
		|| (ctl.flush_el && el_fill_q && !at_limit);

	always_comb begin
		stat = '0;
		stat.bad = (cmd == crb_pkg::CMD_ADD_STD)
			&& (range_begin > crb_pkg::STD_ID_MAX || range_end > crb_pkg::STD_ID_MAX);
		stat.emit = emit;
		stat.full = full;
		stat.done = (last_id == {1'b0, hi_q});
		stat.at_limit = at_limit;
		stat.out_free = out_free;
		stat.sl_nz = (sl_fill_q != 2'd0);
		stat.sm_nz = sm_fill_q;
		stat.el_nz = el_fill_q;
	end

	// control registers: limit, count, fills, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= crb_pkg::BANK_LIMIT_RST;
			bank_count_q <= '0;
			sl_fill_q <= '0;
			sm_fill_q <= 1'b0;
			el_fill_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) limit_q <= cfg_data;
			if (ctl.load && cmd == crb_pkg::CMD_CLEAR) begin
				bank_count_q <= '0;
				sl_fill_q <= '0;
				sm_fill_q <= 1'b0;
				el_fill_q <= 1'b0;
			end
			if (load_bank) bank_count_q <= bank_count_q + 5'd1;
			if (ctl.step) begin
				if (!ext_q && is_list) sl_fill_q <= sl_fill_q + 2'd1;
				else if (!ext_q) sm_fill_q <= !sm_fill_q;
				else if (is_list) el_fill_q <= !el_fill_q;
			end
			if (load_bank || ctl.put_status) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers: range, pending entries, output word
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cur_q <= lo_in;
			hi_q <= hi_in;
			ext_q <= (cmd == crb_pkg::CMD_ADD_EXT);
		end
		if (ctl.step) begin
			cur_q <= cur_q + size[28:0];
			if (!ext_q && is_list) begin
				if (sl_fill_q == 2'd0) begin
					sl_q[0] <= cur_q[10:0];
					sl_q[1] <= cur_q[10:0];
					sl_q[2] <= cur_q[10:0];
					sl_q[3] <= cur_q[10:0];
				end else begin
					sl_q[sl_fill_q] <= cur_q[10:0];
				end
			end else if (!ext_q) begin
				if (!sm_fill_q) begin
					sm_q[0] <= sm_new;
					sm_q[1] <= sm_new;
				end
			end else if (is_list) begin
				if (!el_fill_q) begin
					el_q[0] <= cur_q;
					el_q[1] <= cur_q;
				end
			end
		end
		if (ctl.put_status) begin
			is_status <= 1'b1;
			bank_index <= '0;
			reg_first <= '0;
			reg_second <= '0;
			wide_mode <= 1'b0;
			list_mode <= 1'b0;
			status <= ctl.status;
			last <= 1'b1;
		end else if (load_bank) begin
			is_status <= 1'b0;
			bank_index <= bank_count_q;
			status <= crb_pkg::ST_OK;
			last <= 1'b0;
			if (ctl.step) begin
				reg_first <= r1;
				reg_second <= r2;
				wide_mode <= wide;
				list_mode <= listm;
			end else if (ctl.flush_sl) begin
				reg_first <= {sl_q[1], 5'd0, sl_q[0], 5'd0};
				reg_second <= {sl_q[3], 5'd0, sl_q[2], 5'd0};
				wide_mode <= 1'b0;
				list_mode <= 1'b1;
			end else if (ctl.flush_sm) begin
				reg_first <= {sm_q[0][21:11], 5'd0, sm_q[0][10:0], 5'd0};
				reg_second <= {sm_q[1][21:11], 5'd0, sm_q[1][10:0], 5'd0};
				wide_mode <= 1'b0;
				list_mode <= 1'b0;
			end else begin
				reg_first <= {el_q[0], 3'b100};
				reg_second <= {el_q[1], 3'b100};
				wide_mode <= 1'b1;
				list_mode <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the CAN id range to filter bank packer: directed and random commands.
`timescale 1ns / 100ps
`default_nettype none
module tb;

	localparam int CYCLE_LIMIT = 1500000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [28:0] range_begin;
	logic [28:0] range_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;
	logic        out_valid;
	logic        out_ready;
	logic        is_status;
	logic [4:0]  bank_index;
	logic [31:0] reg_first;
	logic [31:0] reg_second;
	logic        wide_mode;
	logic        list_mode;
	logic [1:0]  status;
	logic        last;

	typedef struct packed {
		logic        is_status;
		logic [4:0]  bank_index;
		logic [31:0] reg_first;
		logic [31:0] reg_second;
		logic        wide_mode;
		logic        list_mode;
		logic [1:0]  status;
		logic        last;
	} bank_word_t;

	// packer state mirror
	logic [4:0]  limit_reg;
	logic [4:0]  banks_used;
	logic [10:0] sl_ids [4];
	logic [1:0]  sl_fill;
	logic [21:0] sm_ents [2];
	logic        sm_fill;
	logic [28:0] el_ids [2];
	logic        el_fill;
	int          words_this_cmd;

	bank_word_t  expected_words [$];
	int          error_count;
	int          words_seen;
	int          cmds_sent;
	int          full_seen;
	int          cycle_count;
	logic        hold_off;
	logic        quiet_out;

	can_id_range_to_filter_banks DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .range_begin(range_begin), .range_end(range_end),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_status(is_status), .bank_index(bank_index),
		.reg_first(reg_first), .reg_second(reg_second),
		.wide_mode(wide_mode), .list_mode(list_mode),
		.status(status), .last(last)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h", what, got, want);
		error_count++;
	endtask

	// push a bank write if a bank is left; return 1 when full or when the command has already put out 63 words
	function automatic logic put_bank(input logic [31:0] r1, input logic [31:0] r2,
			input logic wide, input logic lst);
		int lim;
		bank_word_t w;
		lim = (limit_reg > 28) ? 28 : limit_reg;
		if (banks_used >= lim || words_this_cmd >= 63)
			return 1'b1;
		w = '0;
		w.bank_index = banks_used;
		w.reg_first  = r1;
		w.reg_second = r2;
		w.wide_mode  = wide;
		w.list_mode  = lst;
		expected_words.push_back(w);
		words_this_cmd++;
		banks_used++;
		return 1'b0;
	endfunction

	function automatic logic put_sl();
		return put_bank({sl_ids[1], 5'd0, sl_ids[0], 5'd0},
			{sl_ids[3], 5'd0, sl_ids[2], 5'd0}, 1'b0, 1'b1);
	endfunction

	function automatic logic put_sm();
		logic [31:0] r1, r2;
		r1 = ({21'd0, sm_ents[0][21:11]} << 21) | ({21'd0, sm_ents[0][10:0]} << 5);
		r2 = ({21'd0, sm_ents[1][21:11]} << 21) | ({21'd0, sm_ents[1][10:0]} << 5);
		return put_bank(r1, r2, 1'b0, 1'b0);
	endfunction

	function automatic logic put_el();
		return put_bank({el_ids[0], 3'b100}, {el_ids[1], 3'b100}, 1'b1, 1'b1);
	endfunction

	// split a range into aligned blocks and pack them
	function automatic logic [1:0] pack_range(input logic [28:0] b_in, input logic [28:0] e_in,
			input logic ext);
		logic [31:0] b, e, top, k, bits, msk, cur;
		logic full;
		bits = ext ? 32'd29 : 32'd11;
		top = ext ? 32'h1FFF_FFFF : 32'h7FF;
		b = {3'd0, b_in};
		e = {3'd0, e_in};
		if (b > top || e > top)
			return crb_pkg::ST_RANGE;
		if (b > e) begin
			cur = b;
			b = e;
			e = cur;
		end
		cur = b;
		while (cur <= e) begin
			k = 0;
			while (k < bits && cur[k] == 1'b0)
				k++;
			while (k > 0 && cur + (32'd1 << k) - 1 > e)
				k--;
			msk = (32'hFFFF_FFFF << k) & top;
			full = 1'b0;
			if (!ext) begin
				if (msk == top) begin
					sl_ids[sl_fill] = cur[10:0];
					sl_fill++;
					if (sl_fill == 2'd1) begin
						sl_ids[1] = cur[10:0];
						sl_ids[2] = cur[10:0];
						sl_ids[3] = cur[10:0];
					end else if (sl_fill == 2'd0) begin
						full = put_sl();
					end
				end else begin
					sm_ents[sm_fill] = {msk[10:0], cur[10:0]};
					if (!sm_fill) begin
						sm_ents[1] = {msk[10:0], cur[10:0]};
						sm_fill = 1'b1;
					end else begin
						full = put_sm();
						sm_fill = 1'b0;
					end
				end
			end else if (msk == top) begin
				el_ids[el_fill] = cur[28:0];
				if (!el_fill) begin
					el_ids[1] = cur[28:0];
					el_fill = 1'b1;
				end else begin
					full = put_el();
					el_fill = 1'b0;
				end
			end else begin
				full = put_bank({cur[28:0], 3'b100}, msk << 3, 1'b1, 1'b0);
			end
			if (full)
				return crb_pkg::ST_FULL;
			cur = cur + (32'd1 << k);
		end
		return crb_pkg::ST_OK;
	endfunction

	// work out the words one command causes
	task automatic predict_command(input logic [1:0] c, input logic [28:0] b,
			input logic [28:0] e);
		logic [1:0] st;
		bank_word_t w;
		st = crb_pkg::ST_OK;
		words_this_cmd = 0;
		case (c)
			crb_pkg::CMD_CLEAR: begin
				banks_used = '0;
				sl_fill = '0;
				sm_fill = 1'b0;
				el_fill = 1'b0;
			end
			crb_pkg::CMD_ADD_STD: st = pack_range(b, e, 1'b0);
			crb_pkg::CMD_ADD_EXT: st = pack_range(b, e, 1'b1);
			default: begin
				if (sl_fill != 2'd0 && put_sl())
					st = crb_pkg::ST_FULL;
				if (sm_fill && st == crb_pkg::ST_OK && put_sm())
					st = crb_pkg::ST_FULL;
				if (el_fill && st == crb_pkg::ST_OK && put_el())
					st = crb_pkg::ST_FULL;
			end
		endcase
		if (st == crb_pkg::ST_FULL)
			full_seen++;
		w = '0;
		w.is_status = 1'b1;
		w.status = st;
		w.last = 1'b1;
		expected_words.push_back(w);
	endtask

	// send one command word
	task automatic send_command(input logic [1:0] c, input logic [28:0] b, input logic [28:0] e);
		while (!quiet_out && $urandom_range(99) < 6)
			@(negedge clk);
		predict_command(c, b, e);
		in_valid <= 1'b1;
		cmd <= c;
		range_begin <= b;
		range_end <= e;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		cmds_sent++;
		@(negedge clk);
		in_valid <= 1'b0;
		// hold valid low before the next word
		@(negedge clk);
	endtask

	// drain expectations, then let the block settle
	task automatic wait_idle();
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_limit(input logic [4:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		limit_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// check each accepted word against the oldest expectation
	always @(posedge clk) begin
		bank_word_t w;
		if (arst_n && out_valid && out_ready) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				report("unexpected word", {27'd0, bank_index}, 32'd0);
			end else begin
				w = expected_words.pop_front();
				if (is_status !== w.is_status)
					report("is_status", 32'(is_status), 32'(w.is_status));
				if (bank_index !== w.bank_index)
					report("bank_index", 32'(bank_index), 32'(w.bank_index));
				if (reg_first !== w.reg_first) report("reg_first", reg_first, w.reg_first);
				if (reg_second !== w.reg_second) report("reg_second", reg_second, w.reg_second);
				if (wide_mode !== w.wide_mode)
					report("wide_mode", 32'(wide_mode), 32'(w.wide_mode));
				if (list_mode !== w.list_mode)
					report("list_mode", 32'(list_mode), 32'(w.list_mode));
				if (status !== w.status) report("status", 32'(status), 32'(w.status));
				if (last !== w.last) report("last", 32'(last), 32'(w.last));
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else if (quiet_out)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(99) >= 6);
	end

	task automatic test_standard_ranges();
		send_command(crb_pkg::CMD_CLEAR, 29'd0, 29'd0);
		send_command(crb_pkg::CMD_ADD_STD, 29'h7FF, 29'h7FF);
		send_command(crb_pkg::CMD_FLUSH, 29'd0, 29'd0);
		send_command(crb_pkg::CMD_FLUSH, 29'd0, 29'd0);
		send_command(crb_pkg::CMD_ADD_STD, 29'd0, 29'h7FF);
		send_command(crb_pkg::CMD_ADD_STD, 29'h123, 29'h045);
		send_command(crb_pkg::CMD_ADD_STD, 29'd1, 29'h7FE);
		send_command(crb_pkg::CMD_ADD_STD, 29'h800, 29'd5);
		send_command(crb_pkg::CMD_ADD_STD, 29'd5, 29'h1FFF_FFFF);
		send_command(crb_pkg::CMD_FLUSH, 29'd0, 29'd0);
	endtask

	task automatic test_extended_ranges();
		send_command(crb_pkg::CMD_CLEAR, 29'd0, 29'd0);
		send_command(crb_pkg::CMD_ADD_EXT, 29'h1FFF_FFFF, 29'h1FFF_FFFF);
		send_command(crb_pkg::CMD_ADD_EXT, 29'd0, 29'h1FFF_FFFF);
		send_command(crb_pkg::CMD_ADD_EXT, 29'd1, 29'h1FFF_FFFE);
		send_command(crb_pkg::CMD_ADD_EXT, 29'h1555_5555, 29'h0AAA_AAAA);
		send_command(crb_pkg::CMD_FLUSH, 29'd0, 29'd0);
	endtask

	task automatic test_bank_limits();
		write_limit(5'd1);
		send_command(crb_pkg::CMD_CLEAR, 29'd0, 29'd0);
		send_command(crb_pkg::CMD_ADD_STD, 29'd3, 29'h7FC);
		send_command(crb_pkg::CMD_ADD_EXT, 29'd7, 29'd7);
		send_command(crb_pkg::CMD_FLUSH, 29'd0, 29'd0);
		write_limit(5'd0);
		send_command(crb_pkg::CMD_CLEAR, 29'd0, 29'd0);
		send_command(crb_pkg::CMD_ADD_EXT, 29'd2, 29'd9);
		send_command(crb_pkg::CMD_FLUSH, 29'd0, 29'd0);
		write_limit(5'd31);
		send_command(crb_pkg::CMD_CLEAR, 29'd0, 29'd0);
		send_command(crb_pkg::CMD_ADD_EXT, 29'd1, 29'h1FFF_FFFE);
		send_command(crb_pkg::CMD_ADD_STD, 29'd1, 29'h7FE);
	endtask

	// stall the output long enough to block the input
	task automatic test_output_stall();
		write_limit(5'd28);
		send_command(crb_pkg::CMD_CLEAR, 29'd0, 29'd0);
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				send_command(crb_pkg::CMD_ADD_STD, 29'd1, 29'h7FE);
				send_command(crb_pkg::CMD_ADD_STD, 29'h10, 29'h13);
			end
		join
	endtask

	function automatic logic [28:0] rand_id(input logic ext);
		logic [28:0] v;
		v = 29'($urandom);
		if (!ext)
			v = ($urandom_range(15) == 0) ? v : {18'd0, v[10:0]};
		return v;
	endfunction

	task automatic test_random_traffic();
		logic [1:0] c;
		logic [28:0] b, e;
		int n;
		for (n = 0; n < 350; n++) begin
			if (n == 100)
				write_limit(5'($urandom_range(27) + 1));
			if (n == 200)
				write_limit(5'd28);
			quiet_out = (n >= 250 && n < 300);
			case ($urandom_range(19))
				0: c = crb_pkg::CMD_CLEAR;
				1, 2: c = crb_pkg::CMD_FLUSH;
				3, 4, 5, 6, 7, 8, 9, 10: c = crb_pkg::CMD_ADD_STD;
				default: c = crb_pkg::CMD_ADD_EXT;
			endcase
			if (c == crb_pkg::CMD_CLEAR || banks_used > 20)
				c = ($urandom_range(1) == 0) ? crb_pkg::CMD_CLEAR : c;
			b = rand_id(c == crb_pkg::CMD_ADD_EXT);
			e = ($urandom_range(3) == 0) ? 29'(b + $urandom_range(40))
				: rand_id(c == crb_pkg::CMD_ADD_EXT);
			send_command(c, b, e);
		end
		quiet_out = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = crb_pkg::CMD_CLEAR;
		range_begin = '0;
		range_end = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		out_ready = 1'b0;
		hold_off = 1'b0;
		quiet_out = 1'b0;
		cycle_count = 0;
		error_count = 0;
		words_seen = 0;
		cmds_sent = 0;
		full_seen = 0;
		limit_reg = crb_pkg::BANK_LIMIT_RST;
		banks_used = '0;
		sl_fill = '0;
		sm_fill = 1'b0;
		el_fill = 1'b0;
		for (int i = 0; i < 4; i++)
			sl_ids[i] = '0;
		sm_ents[0] = '0;
		sm_ents[1] = '0;
		el_ids[0] = '0;
		el_ids[1] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_standard_ranges();
		test_extended_ranges();
		test_bank_limits();
		test_output_stall();
		test_random_traffic();
		wait_idle();

		$display("sent %0d commands, checked %0d words, %0d hit the bank limit",
			cmds_sent, words_seen, full_seen);
		$display("limits 0, 1, 14, 28 and above 28 used; one long output stall");
		if (error_count == 0 && expected_words.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
